// File: src/atr_pkg.sv
// ----------------------------------------------------------------------------
// atr_pkg - shared types, constants and functions
// Formats and helpers for the tilt angle relay datapath.
// ----------------------------------------------------------------------------
package atr_pkg;

	localparam int SampleBits    = 16;
	localparam int GuardBits     = 8;
	localparam int AngleFracBits = 7;
	localparam int CordicStages  = 16;
	localparam int GuardW        = SampleBits + GuardBits;   // guarded sample width
	localparam int DatW          = 30;                       // CORDIC x/y width
	localparam int AngW          = 28;                       // internal angle, 2^-16 deg
	localparam int OutW          = 16;
	localparam int CfgIdxW       = 8;
	localparam int KgainQ14      = 26981;

	localparam logic [CfgIdxW-1:0] REG_AZ_THR = CfgIdxW'(0);
	localparam logic [CfgIdxW-1:0] REG_AL_THR = CfgIdxW'(1);
	localparam logic [OutW-1:0]    THR_RESET  = OutW'(23040);

	localparam logic signed [AngW-1:0] DEG180 = AngW'(180 * 65536);
	localparam logic signed [AngW-1:0] DEG360 = AngW'(360 * 65536);

	typedef logic signed [DatW-1:0] dat_t;
	typedef logic signed [AngW-1:0] ang_t;

	// Work item handed from the front to the back.
	typedef struct packed {
		dat_t                     x;
		dat_t                     y;
		ang_t                     a;
		logic                     zero;
		logic signed [GuardW-1:0] gx;
	} work_t;

	// round(atan(2^-i) * 180/pi * 2^16)
	function automatic ang_t atan_tab(input int i);
		ang_t r;
		case (i)
			0:  r = AngW'(2949120);
			1:  r = AngW'(1740967);
			2:  r = AngW'(919879);
			3:  r = AngW'(466945);
			4:  r = AngW'(234379);
			5:  r = AngW'(117304);
			6:  r = AngW'(58666);
			7:  r = AngW'(29335);
			8:  r = AngW'(14668);
			9:  r = AngW'(7334);
			10: r = AngW'(3667);
			11: r = AngW'(1833);
			12: r = AngW'(917);
			13: r = AngW'(458);
			14: r = AngW'(229);
			15: r = AngW'(115);
			16: r = AngW'(57);
			17: r = AngW'(29);
			18: r = AngW'(14);
			19: r = AngW'(7);
			20: r = AngW'(4);
			21: r = AngW'(2);
			22: r = AngW'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

	// Wrap to [0, 360), round half up to the output unit.
	function automatic logic [OutW-1:0] to_output(input ang_t a_in);
		localparam int Sh = 16 - AngleFracBits;
		localparam int Full = 360 << AngleFracBits;
		ang_t w;
		ang_t o;
		w = a_in;
		if (w < 0) w = w + DEG360;
		if (w < 0) w = '0;
		if (w >= DEG360) w = w - DEG360;
		o = (w + AngW'(1 << (Sh - 1))) >>> Sh;
		if (o >= AngW'(Full)) o = o - AngW'(Full);
		return o[OutW-1:0];
	endfunction

endpackage

// File: src/atr_ifs.sv
// ----------------------------------------------------------------------------
// atr_ifs - channel interfaces
// Sample, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface atr_sample_if;
	logic                      valid;
	logic                      ready;
	logic signed [15:0]        accel_x;
	logic signed [15:0]        accel_y;
	logic signed [15:0]        accel_z;
	modport source (output valid, accel_x, accel_y, accel_z, input ready);
	modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface atr_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] azimuth_angle;
	logic [15:0] altitude_angle;
	logic        azimuth_up;
	logic        altitude_up;
	modport source (output valid, azimuth_angle, altitude_angle, azimuth_up, altitude_up,
		input ready);
	modport sink   (input valid, azimuth_angle, altitude_angle, azimuth_up, altitude_up,
		output ready);
endinterface

interface atr_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: src/atr_front.sv
// ----------------------------------------------------------------------------
// atr_front - sample intake
// Scales samples, flags the degenerate case and pre-rotates into the right
// half plane for the azimuth CORDIC.
// ----------------------------------------------------------------------------
module atr_front (
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	output atr_pkg::work_t     item
);
	import atr_pkg::*;

	logic signed [GuardW-1:0] gx, gy, gz;
	dat_t xv, yv;

	always_comb begin
		gx = {accel_x[SampleBits-1:0], {GuardBits{1'b0}}};
		gy = {accel_y[SampleBits-1:0], {GuardBits{1'b0}}};
		gz = {accel_z[SampleBits-1:0], {GuardBits{1'b0}}};
		xv = DatW'(gz);
		yv = DatW'(gy);
		item.gx   = gx;
		item.zero = (gz == '0) && (gy == '0);
		if (xv < 0) begin
			item.a = (yv >= 0) ? DEG180 : -DEG180;
			item.x = -xv;
			item.y = -yv;
		end else begin
			item.a = '0;
			item.x = xv;
			item.y = yv;
		end
	end

endmodule

// File: src/atr_fifo.sv
// ----------------------------------------------------------------------------
// atr_fifo - two entry queue between front and back
// ----------------------------------------------------------------------------
module atr_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  atr_pkg::work_t wdata,
	input  logic           pop,
	output atr_pkg::work_t rdata,
	output logic           full,
	output logic           empty
);
	import atr_pkg::*;

	work_t      mem_q [0:1];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// File: src/atr_cordic.sv
// ----------------------------------------------------------------------------
// atr_cordic - unrolled vectoring CORDIC
// One stage per register, global enable, valid and sideband carried along.
// ----------------------------------------------------------------------------
module atr_cordic (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  atr_pkg::dat_t       x_in,
	input  atr_pkg::dat_t       y_in,
	input  atr_pkg::ang_t       a_in,
	input  logic                zero_in,
	input  logic [23:0]         side_in,
	output logic                out_valid,
	output atr_pkg::dat_t       mag,
	output atr_pkg::ang_t       angle,
	output logic                zero_out,
	output logic [23:0]         side_out
);
	import atr_pkg::*;

	dat_t        x_s [0:CordicStages];
	dat_t        y_s [0:CordicStages];
	ang_t        a_s [0:CordicStages];
	logic        z_s [0:CordicStages];
	logic [23:0] d_s [0:CordicStages];
	logic        v_s [0:CordicStages];

	assign x_s[0] = x_in;
	assign y_s[0] = y_in;
	assign a_s[0] = a_in;
	assign z_s[0] = zero_in;
	assign d_s[0] = side_in;
	assign v_s[0] = in_valid;

	for (genvar i = 0; i < CordicStages; i++) begin : g_stage
		dat_t dx, dy;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					a_s[i+1] <= a_s[i] + atan_tab(i);
				end else begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					a_s[i+1] <= a_s[i] - atan_tab(i);
				end
				z_s[i+1] <= z_s[i];
				d_s[i+1] <= d_s[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i+1] <= 1'b0;
			else if (en) v_s[i+1] <= v_s[i];
		end
	end

	// both operands zero: angle and magnitude are zero
	assign out_valid = v_s[CordicStages];
	assign zero_out  = z_s[CordicStages];
	assign side_out  = d_s[CordicStages];
	assign mag       = z_s[CordicStages] ? '0 : x_s[CordicStages];
	assign angle     = z_s[CordicStages] ? '0 : a_s[CordicStages];

endmodule

// File: src/atr_back.sv
// ----------------------------------------------------------------------------
// atr_back - angle pipeline
// Azimuth CORDIC, gain correction of the pitch numerator, altitude CORDIC,
// output wrap and relay compare.
// ----------------------------------------------------------------------------
module atr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            empty,
	input  atr_pkg::work_t  item,
	output logic            pop,
	input  logic [15:0]     az_thr,
	input  logic [15:0]     al_thr,
	atr_result_if.source    result
);
	import atr_pkg::*;

	logic en;
	logic az_v, az_z, al_v, al_z;
	dat_t az_mag, al_mag;
	ang_t az_ang, al_ang;
	logic [23:0] az_side, al_side;

	logic              m_v_s1;
	dat_t              m_mag_s1, m_num_s1;
	logic              m_zero_s1;
	logic [OutW-1:0]   m_az_s1;
	logic signed [GuardW:0]    neg_gx;
	logic signed [GuardW+16:0] prod;
	logic [OutW-1:0]   al_o;

	logic            out_v_q;
	logic [OutW-1:0] az_q, al_q;
	logic            azu_q, alu_q;

	assign en  = !out_v_q || result.ready;
	assign pop = en && !empty;

	atr_cordic u_az (
		.clk, .arst_n, .en,
		.in_valid (!empty),
		.x_in     (item.x),
		.y_in     (item.y),
		.a_in     (item.a),
		.zero_in  (item.zero),
		.side_in  (item.gx),
		.out_valid(az_v),
		.mag      (az_mag),
		.angle    (az_ang),
		.zero_out (az_z),
		.side_out (az_side)
	);

	assign neg_gx = -((GuardW+1)'(signed'(az_side[GuardW-1:0])));
	assign prod   = neg_gx * (GuardW+17)'(KgainQ14);

	always_ff @(posedge clk) begin
		if (en) begin
			m_mag_s1  <= az_mag;
			m_num_s1  <= DatW'(prod >>> 14);
			m_zero_s1 <= az_z && (az_side == '0);
			m_az_s1   <= to_output(az_ang);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_v_s1 <= 1'b0;
		else if (en) m_v_s1 <= az_v;
	end

	atr_cordic u_al (
		.clk, .arst_n, .en,
		.in_valid (m_v_s1),
		.x_in     (m_mag_s1),
		.y_in     (m_num_s1),
		.a_in     ('0),
		.zero_in  (m_zero_s1),
		.side_in  (24'(m_az_s1)),
		.out_valid(al_v),
		.mag      (al_mag),
		.angle    (al_ang),
		.zero_out (al_z),
		.side_out (al_side)
	);

	assign al_o = to_output(al_ang);

	always_ff @(posedge clk) begin
		if (en) begin
			az_q  <= al_side[OutW-1:0];
			al_q  <= al_o;
			azu_q <= al_side[OutW-1:0] < az_thr;
			alu_q <= al_o < al_thr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (en) out_v_q <= al_v;
	end

	assign result.valid          = out_v_q;
	assign result.azimuth_angle  = az_q;
	assign result.altitude_angle = al_q;
	assign result.azimuth_up     = azu_q;
	assign result.altitude_up    = alu_q;

	// magnitude of the second pass and its zero flag are not needed downstream
	logic unused_al;
	assign unused_al = ^{al_mag, al_z, al_side[23:OutW]};

endmodule

// File: src/accel_tilt_angles_relay_core.sv
// ----------------------------------------------------------------------------
// accel_tilt_angles_relay_core - accelerometer tilt angles and relay select
// Roll and pitch by fixed-point CORDIC, wrapped to [0, 360) degrees.
// ----------------------------------------------------------------------------
// One sample transaction per cycle in, one result transaction per cycle out, as long
// as the result channel takes results. From the queue head to the result register
// lie 2 * 16 CORDIC stages plus the gain multiply stage plus the output register.
// Throughput is set by the fully unrolled CORDIC pipelines, which advance
// together whenever the output register is free or being taken. A two entry
// queue decouples the sample intake from the angle pipeline. Angles come out
// in 1/128 degree; a relay bit is 1 when its angle lies below its threshold.
// Config writes (index 0 azimuth threshold, 1 altitude threshold) are always
// accepted; other indexes are dropped.
// ----------------------------------------------------------------------------
module accel_tilt_angles_relay_core (
	input  logic          clk,
	input  logic          arst_n,
	atr_sample_if.sink    sample,
	atr_result_if.source  result,
	atr_cfg_if.sink       cfg
);
	import atr_pkg::*;

	work_t item_in, item_out;
	logic  full, empty, pop, push;
	logic [OutW-1:0] az_thr_q, al_thr_q;

	// config registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			az_thr_q <= THR_RESET;
			al_thr_q <= THR_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_AZ_THR: az_thr_q <= cfg.data;
				REG_AL_THR: al_thr_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// front: scale and pre-rotate
	atr_front u_front (
		.accel_x (sample.accel_x),
		.accel_y (sample.accel_y),
		.accel_z (sample.accel_z),
		.item    (item_in)
	);

	assign sample.ready = !full;
	assign push         = sample.valid && !full;

	atr_fifo u_fifo (
		.clk, .arst_n,
		.push, .wdata(item_in),
		.pop,  .rdata(item_out),
		.full, .empty
	);

	// back: two CORDIC passes and output stage
	atr_back u_back (
		.clk, .arst_n,
		.empty,
		.item   (item_out),
		.pop,
		.az_thr (az_thr_q),
		.al_thr (al_thr_q),
		.result (result)
	);

endmodule
